// File: design/scfq_pkg.sv
package scfq_pkg;

  // sizing
  localparam int NUM_QUEUES  = 4;
  localparam int QUEUE_DEPTH = 64;
  localparam int COST_REGS   = 4;

  localparam int QIW   = $clog2(NUM_QUEUES);
  localparam int NW    = $clog2(NUM_QUEUES + 1);
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int TAG_W = 48;

  localparam logic [TAG_W-1:0] TAG_MAX = '1;

  // register indexes on the configuration port
  localparam logic [2:0] REG_QUEUES_IN_USE = 3'd0;
  localparam logic [2:0] REG_L2_OVERHEAD   = 3'd1;
  localparam logic [2:0] REG_COST_Q0       = 3'd2;

  // command codes of an input item
  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_FLUSH   = 2'd2
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic enq_calc;
    logic enq_commit;
    logic scan_rd;
    logic scan_cmp;
    logic deq_commit;
    logic misc_commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_cmd;
    logic       out_free;
    logic       scan_last;
  } ctrl_stat_t;

  // flat tag memory address of a queue slot
  function automatic logic [AW-1:0] tag_addr(logic [QIW-1:0] q, logic [PW-1:0] slot);
    return AW'(int'(q) * QUEUE_DEPTH + int'(slot));
  endfunction

endpackage

// File: design/scfq_if.sv
// request channel
interface scfq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  queue_index;
  logic [15:0] packet_bytes;

  modport source (output valid, command, queue_index, packet_bytes, input ready);
  modport sink   (input valid, command, queue_index, packet_bytes, output ready);
endinterface

// response channel
interface scfq_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  selected_queue;
  logic [47:0] finish_tag;
  logic        dropped;

  modport source (output valid, found, selected_queue, finish_tag, dropped, input ready);
  modport sink   (input valid, found, selected_queue, finish_tag, dropped, output ready);
endinterface

// File: design/scfq_ctrl.sv
module scfq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scfq_pkg::ctrl_stat_t   stat_i,
  output scfq_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_MUL,
    ST_ENQ_FIN,
    ST_DEQ_SCAN,
    ST_DEQ_CMP,
    ST_DEQ_FIN,
    ST_MISC_FIN
  } state_e;

  state_e state_q, state_d;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          unique case (stat_i.in_cmd)
            scfq_pkg::CMD_ENQUEUE: state_d = ST_ENQ_MUL;
            scfq_pkg::CMD_DEQUEUE: state_d = ST_DEQ_SCAN;
            default:               state_d = ST_MISC_FIN;
          endcase
        end
      end
      ST_ENQ_MUL: begin
        cmd_o.enq_calc = 1'b1;
        state_d        = ST_ENQ_FIN;
      end
      ST_ENQ_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.enq_commit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_DEQ_SCAN: begin
        cmd_o.scan_rd  = 1'b1;
        cmd_o.scan_cmp = 1'b1;
        if (stat_i.scan_last) state_d = ST_DEQ_CMP;
      end
      ST_DEQ_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = ST_DEQ_FIN;
      end
      ST_DEQ_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.deq_commit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_MISC_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.misc_commit = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // a result is only committed when the output register can take it
  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.enq_commit || cmd_o.deq_commit || cmd_o.misc_commit) |-> stat_i.out_free)
    else $error("commit while output register is occupied");
`endif

endmodule

// File: design/scfq_dp.sv
module scfq_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [31:0]            cfg_wdata_i,
  input  scfq_pkg::ctrl_cmd_t    cmd_i,
  output scfq_pkg::ctrl_stat_t   stat_o,
  scfq_in_if.sink                req,
  scfq_out_if.source             rsp
);

  localparam int QIW   = scfq_pkg::QIW;
  localparam int NW    = scfq_pkg::NW;
  localparam int PW    = scfq_pkg::PW;
  localparam int CW    = scfq_pkg::CW;
  localparam int AW    = scfq_pkg::AW;
  localparam int TAG_W = scfq_pkg::TAG_W;
  localparam int NQ    = scfq_pkg::NUM_QUEUES;
  localparam int DEPTH = scfq_pkg::QUEUE_DEPTH;
  localparam int NCOST = scfq_pkg::COST_REGS;

  // configuration registers
  logic [2:0]        qiu_q;
  logic [7:0]        ovh_q;
  logic [31:0]       cost_q [NCOST];

  // per-queue fifo state and virtual time
  logic [CW-1:0]     count_q [NQ];
  logic [PW-1:0]     head_q  [NQ];
  logic [TAG_W-1:0]  last_q  [NQ];
  logic [TAG_W-1:0]  vt_q;

  // tag memory
  logic [TAG_W-1:0]  tag_mem [NQ*DEPTH];

  // latched item
  logic [1:0]        cmd_q;
  logic [1:0]        qsel_q;
  logic [15:0]       bytes_q;

  // enqueue pipeline
  logic [TAG_W:0]    prod_q;
  logic [TAG_W-1:0]  base_q;
  logic              unused_q;
  logic              full_q;

  // dequeue scan
  logic [QIW-1:0]    idx_q;
  logic [QIW-1:0]    rd_idx_q;
  logic [QIW-1:0]    best_q;
  logic              rd_vld_q;
  logic              any_q;
  logic [TAG_W-1:0]  rdata_q;
  logic [TAG_W-1:0]  best_tag_q;

  // output register
  logic              out_vld_q;
  logic              out_found_q;
  logic [1:0]        out_sel_q;
  logic [TAG_W-1:0]  out_tag_q;
  logic              out_drop_q;

  logic [QIW-1:0]    qi;
  logic [NW-1:0]     nsess;
  logic [16:0]       wire_bytes;
  logic [TAG_W+1:0]  tag_sum;
  logic [TAG_W-1:0]  new_tag;
  logic [PW:0]       slot_sum;
  logic [PW-1:0]     wslot;
  logic              enq_ok;
  logic              enq_we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic              take;
  logic              out_load;
  logic              accept;
  logic [PW-1:0]     best_head_d;

  assign accept = req.valid && cmd_i.in_ready;
  assign qi     = QIW'(qsel_q);
  assign nsess  = (qiu_q < 3'(NQ)) ? NW'(qiu_q) : NW'(NQ);

  // wire bytes and saturating tag sum
  assign wire_bytes = {1'b0, bytes_q} + {9'b0, ovh_q};
  assign tag_sum    = {2'b0, base_q} + {1'b0, prod_q};
  assign new_tag    = (tag_sum > {2'b0, scfq_pkg::TAG_MAX}) ? scfq_pkg::TAG_MAX
                                                            : tag_sum[TAG_W-1:0];

  // tail slot, head plus count wrapped once
  assign slot_sum = (PW+1)'(head_q[qi]) + (PW+1)'(count_q[qi]);
  assign wslot    = (slot_sum >= (PW+1)'(DEPTH)) ? PW'(slot_sum - (PW+1)'(DEPTH))
                                                 : PW'(slot_sum);

  assign enq_ok   = !unused_q && !full_q;
  assign enq_we   = cmd_i.enq_commit && enq_ok;
  assign waddr    = scfq_pkg::tag_addr(qi, wslot);
  assign raddr    = scfq_pkg::tag_addr(idx_q, head_q[idx_q]);
  assign take     = rd_vld_q && (!any_q || (rdata_q < best_tag_q));
  assign out_load = cmd_i.enq_commit || cmd_i.deq_commit || cmd_i.misc_commit;

  assign best_head_d = (head_q[best_q] == PW'(DEPTH - 1)) ? '0 : head_q[best_q] + 1'b1;

  // status and channel wiring
  assign stat_o.in_valid  = req.valid;
  assign stat_o.in_cmd    = req.command;
  assign stat_o.out_free  = !out_vld_q || rsp.ready;
  assign stat_o.scan_last = (idx_q == QIW'(NQ - 1));

  assign req.ready          = cmd_i.in_ready;
  assign rsp.valid          = out_vld_q;
  assign rsp.found          = out_found_q;
  assign rsp.selected_queue = out_sel_q;
  assign rsp.finish_tag     = out_tag_q;
  assign rsp.dropped        = out_drop_q;

  // control state, configuration and queue bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qiu_q     <= 3'd4;
      ovh_q     <= '0;
      for (int i = 0; i < NCOST; i++) cost_q[i] <= 32'd65536;
      for (int i = 0; i < NQ; i++) begin
        count_q[i] <= '0;
        head_q[i]  <= '0;
        last_q[i]  <= '0;
      end
      vt_q      <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      any_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == scfq_pkg::REG_QUEUES_IN_USE) qiu_q <= cfg_wdata_i[2:0];
        if (cfg_idx_i == scfq_pkg::REG_L2_OVERHEAD)   ovh_q <= cfg_wdata_i[7:0];
        for (int i = 0; i < NCOST; i++) begin
          if (cfg_idx_i == scfq_pkg::REG_COST_Q0 + 3'(i)) cost_q[i] <= cfg_wdata_i;
        end
      end

      // scan bookkeeping
      if (accept) begin
        idx_q <= '0;
        any_q <= 1'b0;
      end else if (cmd_i.scan_rd) begin
        idx_q <= idx_q + 1'b1;
      end
      rd_vld_q <= cmd_i.scan_rd && (NW'(idx_q) < nsess) && (count_q[idx_q] != '0);
      if (cmd_i.scan_cmp && take) any_q <= 1'b1;

      // enqueue push
      if (enq_we) begin
        last_q[qi]  <= new_tag;
        count_q[qi] <= count_q[qi] + 1'b1;
      end

      // dequeue pop
      if (cmd_i.deq_commit && any_q) begin
        vt_q            <= best_tag_q;
        head_q[best_q]  <= best_head_d;
        count_q[best_q] <= count_q[best_q] - 1'b1;
      end

      // flush
      if (cmd_i.misc_commit && (cmd_q == scfq_pkg::CMD_FLUSH)) begin
        for (int i = 0; i < NQ; i++) begin
          count_q[i] <= '0;
          head_q[i]  <= '0;
          last_q[i]  <= '0;
        end
        vt_q <= '0;
      end

      // output valid
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= req.command;
      qsel_q  <= req.queue_index;
      bytes_q <= req.packet_bytes;
    end

    // multiply stage; queue_index is two bits so it always names a cost register
    if (cmd_i.enq_calc) begin
      prod_q   <= (TAG_W+1)'(wire_bytes * cost_q[qsel_q]);
      base_q   <= (last_q[qi] > vt_q) ? last_q[qi] : vt_q;
      unused_q <= (32'(qsel_q) >= 32'(nsess));
      full_q   <= (count_q[qi] >= CW'(DEPTH));
    end

    if (cmd_i.scan_rd) rd_idx_q <= idx_q;
    if (cmd_i.scan_cmp && take) begin
      best_q     <= rd_idx_q;
      best_tag_q <= rdata_q;
    end

    if (cmd_i.enq_commit) begin
      out_found_q <= enq_ok;
      out_sel_q   <= qsel_q;
      out_tag_q   <= enq_ok ? new_tag : '0;
      out_drop_q  <= !unused_q && full_q;
    end else if (cmd_i.deq_commit) begin
      out_found_q <= any_q;
      out_sel_q   <= any_q ? 2'(best_q) : 2'd0;
      out_tag_q   <= any_q ? best_tag_q : '0;
      out_drop_q  <= 1'b0;
    end else if (cmd_i.misc_commit) begin
      out_found_q <= 1'b0;
      out_sel_q   <= 2'd0;
      out_tag_q   <= '0;
      out_drop_q  <= 1'b0;
    end
  end

  // tag memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (enq_we) tag_mem[waddr] <= new_tag;
    if (cmd_i.scan_rd) rdata_q <= tag_mem[raddr];
  end

`ifndef SYNTHESIS
  // a served queue always held a tag
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.deq_commit && any_q) |-> (count_q[best_q] != '0))
    else $error("dequeue from an empty queue");

  // serving a tag moves virtual time to it
  a_vt_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.deq_commit && any_q) |=> (vt_q == out_tag_q))
    else $error("virtual time does not match served tag");

  // a new tag never lies before virtual time
  a_tag_after_vt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.enq_commit && enq_ok) |=> (out_tag_q >= vt_q))
    else $error("enqueued tag earlier than virtual time");
`endif

endmodule

// File: design/self_clocked_fair_queue_scheduler_core.sv
// Self-clocked fair queueing scheduler.
// Request channel req_i carries command, queue_index and packet_bytes; every
// request transfer gives exactly one response transfer on rsp_o (found,
// selected_queue, finish_tag, dropped), in request order.
// Enqueue steps per item: accept, 17x32 multiply stage, then saturating add
// and tag memory write. Dequeue steps: accept, then the scan that reads one
// head tag per cycle through the single read port of the tag memory, then a
// compare step and a commit step. Flush and the unused command code go from
// accept straight to commit.
// The response sits in an output register; the next request is taken while it
// waits. If the receiver stalls with a response still held, the block finishes
// its current item and waits before committing the next result, so nothing is
// lost or reordered.
// Reset (rst_ni low) empties all queues, zeroes virtual time and last tags and
// loads register defaults; no clearing pass is needed. Configuration writes on
// cfg_we_i/cfg_idx_i/cfg_wdata_i are registered directly and belong in idle time.
module self_clocked_fair_queue_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  scfq_in_if.sink     req_i,
  scfq_out_if.source  rsp_o
);

  scfq_pkg::ctrl_cmd_t  cmd;
  scfq_pkg::ctrl_stat_t stat;

  // sequencer
  scfq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // tags, fifos and output register
  scfq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req         (req_i),
    .rsp         (rsp_o)
  );

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAG_W       = scfq_pkg::TAG_W;
  localparam int NUM_QUEUES  = scfq_pkg::NUM_QUEUES;
  localparam int QUEUE_DEPTH = scfq_pkg::QUEUE_DEPTH;
  localparam int COST_REGS   = scfq_pkg::COST_REGS;

  localparam logic [1:0] CMD_RSVD = 2'd3;
  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 300;

  typedef struct packed {
    logic             found;
    logic [1:0]       selected_queue;
    logic [TAG_W-1:0] finish_tag;
    logic             dropped;
  } sched_rsp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  scfq_in_if  req_if();
  scfq_out_if rsp_if();

  self_clocked_fair_queue_scheduler_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // scheduler state mirrored by the predictor
  logic [TAG_W-1:0] tag_mem [NUM_QUEUES][QUEUE_DEPTH];
  int unsigned      head_ptr [NUM_QUEUES];
  int unsigned      depth_cnt [NUM_QUEUES];
  logic [TAG_W-1:0] last_finish [NUM_QUEUES];
  logic [TAG_W-1:0] vtime;

  // mirrored registers
  logic [2:0]  sessions_reg;
  logic [7:0]  overhead_reg;
  logic [31:0] cost_reg [COST_REGS];

  sched_rsp_t pending_rsps [$];
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  bit         idle_on = 1'b0;
  bit         long_hold = 1'b0;
  bit         hold_done = 1'b0;
  int         rsp_gap = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // empty every session and the virtual time
  function automatic void clear_sessions();
    for (int i = 0; i < NUM_QUEUES; i++) begin
      head_ptr[i]    = 0;
      depth_cnt[i]   = 0;
      last_finish[i] = '0;
    end
    vtime = '0;
  endfunction

  function automatic void reset_scheduler_state();
    for (int i = 0; i < NUM_QUEUES; i++)
      for (int j = 0; j < QUEUE_DEPTH; j++)
        tag_mem[i][j] = '0;
    clear_sessions();
    sessions_reg = 3'd4;
    overhead_reg = 8'd0;
    for (int i = 0; i < COST_REGS; i++)
      cost_reg[i] = 32'd65536;
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [31:0] val);
    if (idx == scfq_pkg::REG_QUEUES_IN_USE) begin
      sessions_reg = val[2:0];
    end else if (idx == scfq_pkg::REG_L2_OVERHEAD) begin
      overhead_reg = val[7:0];
    end else if (idx >= scfq_pkg::REG_COST_Q0 && idx < scfq_pkg::REG_COST_Q0 + COST_REGS) begin
      cost_reg[idx - scfq_pkg::REG_COST_Q0] = val;
    end
  endfunction

  function automatic int active_sessions();
    return (sessions_reg > NUM_QUEUES) ? NUM_QUEUES : int'(sessions_reg);
  endfunction

  // expected response of one request, updating the mirrored state
  function automatic sched_rsp_t predict_schedule(input logic [1:0] cmd, input logic [1:0] q,
                                                  input logic [15:0] bytes);
    sched_rsp_t       r;
    int               n;
    int unsigned      slot;
    int               best;
    bit               any;
    logic [63:0]      base;
    logic [63:0]      incr;
    logic [63:0]      room;
    logic [TAG_W-1:0] tag;
    logic [TAG_W-1:0] best_tag;
    r = '0;
    n = active_sessions();
    case (cmd)
      scfq_pkg::CMD_ENQUEUE: begin
        r.selected_queue = q;
        if (int'(q) < n) begin
          if (depth_cnt[q] >= QUEUE_DEPTH) begin
            r.dropped = 1'b1;
          end else begin
            base = (last_finish[q] > vtime) ? 64'(last_finish[q]) : 64'(vtime);
            incr = (64'(bytes) + 64'(overhead_reg)) * 64'(cost_reg[q]);
            room = 64'(scfq_pkg::TAG_MAX) - base;
            tag  = (incr > room) ? scfq_pkg::TAG_MAX : TAG_W'(base + incr);
            last_finish[q] = tag;
            slot = (head_ptr[q] + depth_cnt[q]) % QUEUE_DEPTH;
            tag_mem[q][slot] = tag;
            depth_cnt[q]++;
            r.found      = 1'b1;
            r.finish_tag = tag;
          end
        end
      end
      scfq_pkg::CMD_DEQUEUE: begin
        any = 1'b0;
        best = 0;
        best_tag = '0;
        for (int i = 0; i < n; i++) begin
          if (depth_cnt[i] != 0) begin
            if (!any || tag_mem[i][head_ptr[i]] < best_tag) begin
              any = 1'b1;
              best = i;
              best_tag = tag_mem[i][head_ptr[i]];
            end
          end
        end
        if (any) begin
          vtime = best_tag;
          head_ptr[best] = (head_ptr[best] + 1) % QUEUE_DEPTH;
          depth_cnt[best]--;
          r.found          = 1'b1;
          r.selected_queue = 2'(best);
          r.finish_tag     = best_tag;
        end
      end
      scfq_pkg::CMD_FLUSH: begin
        clear_sessions();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // one request transfer, with an optional gap before it
  task automatic send_item(input logic [1:0] cmd, input logic [1:0] q, input logic [15:0] bytes);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.command      <= cmd;
    req_if.queue_index  <= q;
    req_if.packet_bytes <= bytes;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_rsps.push_back(predict_schedule(cmd, q, bytes));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller lowers it
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    store_reg(idx, val);
  endtask

  // program every register while the block is idle
  task automatic apply_config(input logic [2:0] sessions, input logic [7:0] ovh,
                              input logic [31:0] c0, input logic [31:0] c1,
                              input logic [31:0] c2, input logic [31:0] c3);
    wait_drained();
    write_reg(scfq_pkg::REG_QUEUES_IN_USE, {29'd0, sessions});
    write_reg(scfq_pkg::REG_L2_OVERHEAD, {24'd0, ovh});
    write_reg(scfq_pkg::REG_COST_Q0, c0);
    write_reg(scfq_pkg::REG_COST_Q0 + 3'd1, c1);
    write_reg(scfq_pkg::REG_COST_Q0 + 3'd2, c2);
    write_reg(scfq_pkg::REG_COST_Q0 + 3'd3, c3);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_bytes();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd64;
      3:       return 16'd1500;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // 0 small, 1 full range, 2 extremes
  function automatic logic [31:0] pick_cost(input int mode);
    case (mode)
      0:       return 32'($urandom_range(1, 65536));
      1:       return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'd0;
          1:       return 32'd1;
          2:       return 32'hFFFF_FFFF;
          default: return 32'd65536;
        endcase
      end
    endcase
  endfunction

  // mostly requests for active sessions, some noise
  task automatic random_phase(input int n_items, input int enq_pct, input int deq_pct);
    int         r;
    int         n;
    logic [1:0] cmd;
    logic [1:0] q;
    n = active_sessions();
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) cmd = scfq_pkg::CMD_ENQUEUE;
      else if (r < enq_pct + deq_pct) cmd = scfq_pkg::CMD_DEQUEUE;
      else if (r % 2 == 0) cmd = scfq_pkg::CMD_FLUSH;
      else cmd = CMD_RSVD;
      if (n == 0 || $urandom_range(0, 4) == 0) q = 2'($urandom_range(0, 3));
      else q = 2'($urandom_range(0, n - 1));
      send_item(cmd, q, pick_bytes());
    end
  endtask

  // defaults after reset: ordering, ties, empty dequeue, flush, unused command
  task automatic test_directed();
    idle_on = 1'b1;
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd1, 16'hFFFF);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd2, 16'd1500);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd3, 16'd1500);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd1, 16'd64);
    send_item(CMD_RSVD, 2'd3, 16'hFFFF);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd3, 16'hFFFF);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd0, 16'd64);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd2, 16'd100);
    send_item(scfq_pkg::CMD_FLUSH, 2'd2, 16'd100);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd3, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
  endtask

  // tags pinned at the maximum, ties among saturated heads
  task automatic test_saturation();
    apply_config(3'd4, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd0, 16'hFFFF);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd1, 16'd1);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd2, 16'hFFFF);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd3, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_FLUSH, 2'd0, 16'd0);
  endtask

  // session count of zero, reduced, and above the number of queues
  task automatic test_unused_sessions();
    apply_config(3'd0, 8'd0, 32'd65536, 32'd65536, 32'd65536, 32'd65536);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd0, 16'd100);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    apply_config(3'd2, 8'd16, 32'd1, 32'd2, 32'd3, 32'd4);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd2, 16'd10);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd3, 16'd10);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd1, 16'd10);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd0, 16'd20);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    apply_config(3'd7, 8'd0, 32'd5, 32'd5, 32'd5, 32'd5);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd3, 16'd7);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_FLUSH, 2'd0, 16'd0);
  endtask

  // zero cost leaves the tag at its base
  task automatic test_zero_cost();
    apply_config(3'd4, 8'd255, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd0, 16'hFFFF);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd1, 16'd0);
    send_item(scfq_pkg::CMD_ENQUEUE, 2'd3, 16'd1000);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
    send_item(scfq_pkg::CMD_FLUSH, 2'd0, 16'd0);
  endtask

  // long receiver hold-off while one session overflows
  task automatic test_fifo_full_backpressure();
    apply_config(3'd4, 8'($urandom_range(0, 255)), pick_cost(0), pick_cost(0),
                 pick_cost(0), pick_cost(0));
    send_item(scfq_pkg::CMD_FLUSH, 2'd0, 16'd0);
    long_hold = 1'b1;
    for (int k = 0; k < QUEUE_DEPTH + 6; k++)
      send_item(scfq_pkg::CMD_ENQUEUE, 2'd2, pick_bytes());
    for (int k = 0; k < QUEUE_DEPTH + 2; k++)
      send_item(scfq_pkg::CMD_DEQUEUE, 2'd0, 16'd0);
  endtask

  // random phases over several settings, the last one without idling
  task automatic test_random();
    logic [31:0] same_cost;
    idle_on = 1'b1;
    apply_config(3'd4, 8'd0, pick_cost(0), pick_cost(0), pick_cost(0), pick_cost(0));
    random_phase(40, 50, 45);
    apply_config(3'd1, 8'd255, pick_cost(0), pick_cost(0), pick_cost(0), pick_cost(0));
    random_phase(60, 85, 12);
    apply_config(3'd0, 8'($urandom_range(0, 255)), pick_cost(1), pick_cost(1),
                 pick_cost(1), pick_cost(1));
    random_phase(10, 50, 45);
    apply_config(3'd7, 8'($urandom_range(0, 255)), pick_cost(1), pick_cost(1),
                 pick_cost(1), pick_cost(1));
    random_phase(40, 55, 40);
    apply_config(3'd3, 8'($urandom_range(0, 255)), pick_cost(2), pick_cost(0),
                 pick_cost(2), pick_cost(0));
    random_phase(35, 50, 45);
    same_cost = pick_cost(0);
    apply_config(3'd2, 8'($urandom_range(0, 255)), same_cost, same_cost, same_cost, same_cost);
    random_phase(40, 55, 40);
    wait_drained();
    idle_on = 1'b0;
    apply_config(3'd4, 8'($urandom_range(0, 255)), pick_cost(0), pick_cost(1),
                 pick_cost(0), pick_cost(1));
    random_phase(40, 50, 45);
  endtask

  // response ready with random stall bursts and one long hold-off
  always @(posedge clk_i) begin
    if (long_hold && !hold_done) begin
      rsp_gap   = LONG_HOLD;
      hold_done = 1'b1;
    end else if (rsp_gap == 0 && idle_on && $urandom_range(0, 5) == 0) begin
      rsp_gap = $urandom_range(1, 10);
    end
    if (rsp_gap > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_gap--;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // compare each response transfer with the oldest expectation
  always @(posedge clk_i) begin
    sched_rsp_t got;
    sched_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.found          = rsp_if.found;
      got.selected_queue = rsp_if.selected_queue;
      got.finish_tag     = rsp_if.finish_tag;
      got.dropped        = rsp_if.dropped;
      if (pending_rsps.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected response found=%0b queue=%0d tag=%h dropped=%0b", $time,
                 got.found, got.selected_queue, got.finish_tag, got.dropped);
      end else begin
        want = pending_rsps.pop_front();
        if (got !== want) begin
          err_cnt++;
          $display("%0t: mismatch expected found=%0b queue=%0d tag=%h dropped=%0b", $time,
                   want.found, want.selected_queue, want.finish_tag, want.dropped);
          $display("%0t:          actual found=%0b queue=%0d tag=%h dropped=%0b", $time,
                   got.found, got.selected_queue, got.finish_tag, got.dropped);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = scfq_pkg::REG_QUEUES_IN_USE;
    cfg_wdata           = '0;
    req_if.valid        = 1'b0;
    req_if.command      = scfq_pkg::CMD_ENQUEUE;
    req_if.queue_index  = '0;
    req_if.packet_bytes = '0;
    reset_scheduler_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_unused_sessions();
    test_zero_cost();
    test_fifo_full_backpressure();
    test_random();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
